### rtl/core/lpbd_pkg.sv
// Shared types and constants for the length-prefixed block deframer.
// No dependencies; imported by every module of the block.
`default_nettype none

package lpbd_pkg;

    // Expected version byte after reset
    localparam logic [7:0] VERSION_DEFAULT = 8'hB1;

    // Register map: register index is paddr[2]
    localparam logic REG_VERSION = 1'b0;

    // Front-to-back queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_EMPTY   = 2'd1,
        KIND_DONE    = 2'd2,
        KIND_ERROR   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE         = 2'd0,
        ERR_SHORT_HEADER = 2'd1,
        ERR_BAD_VERSION  = 2'd2,
        ERR_TRUNCATED    = 2'd3
    } err_t;

    typedef enum logic [7:0] {
        PH_VERSION  = 8'b0000_0001,
        PH_COUNT_HI = 8'b0000_0010,
        PH_COUNT_LO = 8'b0000_0100,
        PH_LEN_HI   = 8'b0000_1000,
        PH_LEN_LO   = 8'b0001_0000,
        PH_PAYLOAD  = 8'b0010_0000,
        PH_DONE     = 8'b0100_0000,
        PH_SKIP     = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  payload;
        logic [15:0] block_index;
        logic        block_end;
        err_t        error_code;
    } result_t;

    // Everything one input item produces: one or two results
    typedef struct packed {
        logic    two;
        result_t first;
        result_t second;
    } bundle_t;

    function automatic result_t make_result(kind_t k, logic [7:0] p, logic [15:0] idx,
                                            logic be, err_t e);
        result_t r;
        r.kind        = k;
        r.payload     = p;
        r.block_index = idx;
        r.block_end   = be;
        r.error_code  = e;
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/core/lpbd_front.sv
// Parser front end: accepts message bytes, tracks framing state, builds result bundles.
// Depends on lpbd_pkg.
`default_nettype none

module lpbd_front
    import lpbd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] version_byte,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] data_byte,
    input  wire logic       end_of_message,
    input  wire logic       q_full,
    output logic            push,
    output bundle_t         push_data
);

    phase_t      phase_reg, phase_next;
    logic [15:0] blocks_total_reg, blocks_total_next;
    logic [15:0] block_number_reg, block_number_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic [7:0]  high_reg, high_next;

    logic        accept;
    logic        have0, have1;
    result_t     r0, r1;
    logic [15:0] word, bn_inc, bl_dec;
    logic        last_block;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    assign word       = {high_reg, data_byte};
    assign bn_inc     = block_number_reg + 16'd1;
    assign bl_dec     = bytes_left_reg - 16'd1;
    assign last_block = (bn_inc == blocks_total_reg);

    always_comb
    begin
        phase_next        = phase_reg;
        blocks_total_next = blocks_total_reg;
        block_number_next = block_number_reg;
        bytes_left_next   = bytes_left_reg;
        high_next         = high_reg;
        have0             = 1'b0;
        have1             = 1'b0;
        r0 = make_result(KIND_ERROR, 8'd0, 16'd0, 1'b0, ERR_TRUNCATED);
        r1 = make_result(KIND_ERROR, 8'd0, 16'd0, 1'b0, ERR_TRUNCATED);

        case (phase_reg)
            PH_VERSION:
            begin
                if (end_of_message)
                begin
                    have0 = 1'b1;
                    r0 = make_result(KIND_ERROR, 8'd0, 16'd0, 1'b0, ERR_SHORT_HEADER);
                end
                else if (data_byte != version_byte)
                begin
                    have0 = 1'b1;
                    r0 = make_result(KIND_ERROR, 8'd0, 16'd0, 1'b0, ERR_BAD_VERSION);
                    phase_next = PH_SKIP;
                end
                else
                begin
                    phase_next = PH_COUNT_HI;
                end
            end
            PH_COUNT_HI:
            begin
                high_next = data_byte;
                if (end_of_message)
                begin
                    have0 = 1'b1;
                    r0 = make_result(KIND_ERROR, 8'd0, 16'd0, 1'b0, ERR_SHORT_HEADER);
                end
                else
                begin
                    phase_next = PH_COUNT_LO;
                end
            end
            PH_COUNT_LO:
            begin
                blocks_total_next = word;
                block_number_next = 16'd0;
                if (word == 16'd0)
                begin
                    have0 = 1'b1;
                    r0 = make_result(KIND_DONE, 8'd0, 16'd0, 1'b0, ERR_NONE);
                    phase_next = PH_DONE;
                end
                else if (end_of_message)
                begin
                    have0 = 1'b1;
                end
                else
                begin
                    phase_next = PH_LEN_HI;
                end
            end
            PH_LEN_HI:
            begin
                high_next = data_byte;
                if (end_of_message)
                begin
                    have0 = 1'b1;
                end
                else
                begin
                    phase_next = PH_LEN_LO;
                end
            end
            PH_LEN_LO:
            begin
                bytes_left_next = word;
                if (word == 16'd0)
                begin
                    // empty block, then the block is finished
                    have0 = 1'b1;
                    r0 = make_result(KIND_EMPTY, 8'd0, block_number_reg, 1'b1, ERR_NONE);
                    block_number_next = bn_inc;
                    if (last_block)
                    begin
                        have1 = 1'b1;
                        r1 = make_result(KIND_DONE, 8'd0, 16'd0, 1'b0, ERR_NONE);
                        phase_next = PH_DONE;
                    end
                    else if (end_of_message)
                    begin
                        have1 = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_LEN_HI;
                    end
                end
                else if (end_of_message)
                begin
                    have0 = 1'b1;
                end
                else
                begin
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                have0 = 1'b1;
                r0 = make_result(KIND_PAYLOAD, data_byte, block_number_reg,
                                 bytes_left_reg == 16'd1, ERR_NONE);
                bytes_left_next = bl_dec;
                if (bl_dec == 16'd0)
                begin
                    block_number_next = bn_inc;
                    if (last_block)
                    begin
                        have1 = 1'b1;
                        r1 = make_result(KIND_DONE, 8'd0, 16'd0, 1'b0, ERR_NONE);
                        phase_next = PH_DONE;
                    end
                    else if (end_of_message)
                    begin
                        have1 = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_LEN_HI;
                    end
                end
                else if (end_of_message)
                begin
                    have1 = 1'b1;
                end
            end
            default:
            begin
                // done or skipping: trailing bytes give nothing
            end
        endcase

        if (end_of_message)
        begin
            phase_next = PH_VERSION;
        end
    end

    assign push             = accept && have0;
    assign push_data.two    = have1;
    assign push_data.first  = r0;
    assign push_data.second = r1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_VERSION;
            blocks_total_reg <= 16'd0;
            block_number_reg <= 16'd0;
            bytes_left_reg   <= 16'd0;
            high_reg         <= 8'd0;
        end
        else if (accept)
        begin
            phase_reg        <= phase_next;
            blocks_total_reg <= blocks_total_next;
            block_number_reg <= block_number_next;
            bytes_left_reg   <= bytes_left_next;
            high_reg         <= high_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/lpbd_queue.sv
// Small FIFO of result bundles between parser front and output back end.
// Depends on lpbd_pkg.
`default_nettype none

module lpbd_queue
    import lpbd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  bundle_t      push_data,
    output logic         full,
    output logic         head_valid,
    output bundle_t      head_data,
    input  wire logic    pop
);

    bundle_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]     count_reg, count_next;
    logic                do_pop;

    assign full       = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = entry_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

### rtl/core/lpbd_back.sv
// Output back end: unpacks each bundle into one or two results behind an output register.
// Depends on lpbd_pkg.
`default_nettype none

module lpbd_back
    import lpbd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    head_valid,
    input  bundle_t      head_data,
    output logic         pop,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_result,
    output logic         out_last
);

    logic    out_valid_reg, out_valid_next;
    logic    sub_reg, sub_next;
    result_t res_reg;
    logic    last_reg;
    logic    load, take, last_sel;
    result_t sel;

    // output register free or being emptied this cycle
    assign load     = !out_valid_reg || out_ready;
    assign take     = head_valid && load;
    assign last_sel = sub_reg || !head_data.two;
    assign pop      = take && last_sel;
    assign sel      = sub_reg ? head_data.second : head_data.first;

    always_comb
    begin
        out_valid_next = load ? head_valid : out_valid_reg;
        sub_next       = take ? !last_sel : sub_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sub_reg       <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            sub_reg       <= sub_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg  <= sel;
            last_reg <= last_sel;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = res_reg;
    assign out_last   = last_reg;

endmodule

`default_nettype wire

### rtl/core/length_prefixed_block_deframer.sv
// Top level of the length-prefixed block deframer: APB register, front, queue, back.
// Depends on lpbd_pkg, lpbd_front, lpbd_queue and lpbd_back.
`default_nettype none

// Deframes messages fed one byte per item (last byte flagged by end_of_message):
// a version byte, a 16-bit big-endian block count, then per block a 16-bit
// big-endian length and that many payload bytes. Each payload byte comes out
// as a kind-0 result tagged with its block index and end-of-block flag; an
// empty block gives one kind-1 result; the end of the last block gives a
// kind-2 result; errors (short header, bad version, truncated block) give a
// kind-3 result as soon as they are seen, and the rest of the message is
// skipped. Results already emitted for a failed message are for downstream
// to discard. last_result marks the final result caused by one input byte.
// Rate: one input byte per cycle. Most bytes cause at most one result; a
// payload or empty-block byte that also completes the last block, or that
// ends the message with blocks still due, causes two, which leave the
// output port as two separate transfers. A 4-item queue of result bundles
// sits between the parser and the output register, so input stalls only when
// that queue is full; a result is registered in the queue, then at the output.
// The version register sits at APB address 0 (reset 0xB1); write it only
// while the block is idle.

module length_prefixed_block_deframer
    import lpbd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // APB-style configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // input items
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        end_of_message,
    // result items
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       kind,
    output logic [7:0]       payload,
    output logic [15:0]      block_index,
    output logic             block_end,
    output logic [1:0]       error_code,
    output logic             last_result
);

    logic [7:0] version_reg;
    logic       cfg_write;

    logic       push;
    bundle_t    push_data;
    logic       q_full;
    logic       head_valid;
    bundle_t    head_data;
    logic       pop;
    result_t    out_result;

    // --- configuration register ---
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_VERSION);
    assign prdata    = (paddr[2] == REG_VERSION) ? {24'd0, version_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            version_reg <= VERSION_DEFAULT;
        end
        else if (cfg_write)
        begin
            version_reg <= pwdata[7:0];
        end
    end

    // --- parser front: classifies each byte, one per cycle while the queue is not full ---
    lpbd_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .version_byte   (version_reg),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .end_of_message (end_of_message),
        .q_full         (q_full),
        .push           (push),
        .push_data      (push_data)
    );

    // --- bundle queue decouples the two sides ---
    lpbd_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (q_full),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop)
    );

    // --- back end: one result per cycle onto the output register, unless out_ready holds it ---
    lpbd_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_result (out_result),
        .out_last   (last_result)
    );

    assign kind        = out_result.kind;
    assign payload     = out_result.payload;
    assign block_index = out_result.block_index;
    assign block_end   = out_result.block_end;
    assign error_code  = out_result.error_code;

    // --- checks ---

    // the second result of a pair follows straight on from the first
    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_result |=> out_valid)
        else $error("second result of a pair not presented");

    // input only stalls on a full queue, which then has something to drain
    a_stall_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> head_valid)
        else $error("input stalled with empty queue");

    // error code only travels with error results
    a_err_only_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind != KIND_ERROR) |-> (error_code == ERR_NONE))
        else $error("error code on non-error result");

    // payload byte only on payload results
    a_payload_only_on_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind != KIND_PAYLOAD) |-> (payload == 8'd0))
        else $error("payload on non-payload result");

endmodule

`default_nettype wire

### dv/tb.sv
// Self-checking testbench for length_prefixed_block_deframer: an in-bench predictor,
// an ordered result check, and directed and random message traffic.
// Depends on lpbd_pkg and the deframer RTL only.

module tb;
    import lpbd_pkg::*;

    // ------------------------------------------------------------------
    // Run limits and timing
    // ------------------------------------------------------------------
    localparam int CYCLE_LIMIT  = 400000; // many times the slowest legal run
    localparam int DRAIN_CYCLES = 6;      // queue and output register plus margin
    localparam int HOLD_CYCLES  = 150;    // long receiver hold-off
    localparam int PHASE_ITEMS  = 350;    // parsed items per random phase

    // Register addresses: index i at byte address 4*i
    localparam logic [2:0] ADDR_VERSION  = {REG_VERSION, 2'b00};
    localparam logic [2:0] ADDR_UNMAPPED = {~REG_VERSION, 2'b00};

    // One predicted result with its end-of-item mark
    typedef struct packed {
        result_t res;
        logic    last;
    } deframed_t;

    // ------------------------------------------------------------------
    // Block ports
    // ------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        end_of_message;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  kind;
    logic [7:0]  payload;
    logic [15:0] block_index;
    logic        block_end;
    logic [1:0]  error_code;
    logic        last_result;

    length_prefixed_block_deframer dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .payload        (payload),
        .block_index    (block_index),
        .block_end      (block_end),
        .error_code     (error_code),
        .last_result    (last_result)
    );

    // 2-unit period
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the parser and its register
    // ------------------------------------------------------------------
    logic [7:0]  cfg_version;
    phase_t      ph;
    logic [15:0] blocks_due;   // block count from the header
    logic [15:0] block_no;     // block currently being parsed
    logic [15:0] bytes_due;    // payload bytes still to come in this block
    logic [7:0]  hi_hold;      // high byte of a count or length field

    deframed_t   deframed_q[$];  // results predicted, oldest first
    logic [7:0]  frame_q[$];     // message being built for sending

    int          mismatches   = 0;
    int          parsed_items = 0; // items the parser acted on (not skipped)
    int          cycle_count  = 0;
    bit          gaps_on      = 1'b1; // random idling on both sides
    bit          hold_off     = 1'b0; // request for one long receiver stall

    function automatic void emit(input kind_t k, input logic [7:0] p,
                                 input logic [15:0] idx, input logic be, input err_t e);
        deframed_t d;
        d.res.kind        = k;
        d.res.payload     = p;
        d.res.block_index = idx;
        d.res.block_end   = be;
        d.res.error_code  = e;
        d.last            = 1'b0;
        deframed_q.push_back(d);
    endfunction

    // A block has just closed: either the message is complete, or it was
    // cut short here, or the next length field follows.
    function automatic void close_block(input logic eom);
        block_no = block_no + 16'd1;
        if (block_no == blocks_due)
        begin
            emit(KIND_DONE, 8'h00, 16'h0000, 1'b0, ERR_NONE);
            ph = PH_DONE;
        end
        else if (eom)
            emit(KIND_ERROR, 8'h00, 16'h0000, 1'b0, ERR_TRUNCATED);
        else
            ph = PH_LEN_HI;
    endfunction

    // Predict the results of one accepted item.
    function automatic void model_byte(input logic [7:0] b, input logic eom);
        int        prior_size;
        deframed_t tail;
        prior_size = deframed_q.size();
        if (ph != PH_DONE && ph != PH_SKIP)
            parsed_items++;
        case (ph)
            PH_VERSION:
            begin
                // a wrong version that also ends the message counts as short header
                if (eom)
                    emit(KIND_ERROR, 8'h00, 16'h0000, 1'b0, ERR_SHORT_HEADER);
                else if (b != cfg_version)
                begin
                    emit(KIND_ERROR, 8'h00, 16'h0000, 1'b0, ERR_BAD_VERSION);
                    ph = PH_SKIP;
                end
                else
                    ph = PH_COUNT_HI;
            end
            PH_COUNT_HI:
            begin
                hi_hold = b;
                if (eom)
                    emit(KIND_ERROR, 8'h00, 16'h0000, 1'b0, ERR_SHORT_HEADER);
                else
                    ph = PH_COUNT_LO;
            end
            PH_COUNT_LO:
            begin
                blocks_due = {hi_hold, b};
                block_no   = 16'h0000;
                if (blocks_due == 16'h0000)
                begin
                    emit(KIND_DONE, 8'h00, 16'h0000, 1'b0, ERR_NONE);
                    ph = PH_DONE;
                end
                else if (eom)
                    emit(KIND_ERROR, 8'h00, 16'h0000, 1'b0, ERR_TRUNCATED);
                else
                    ph = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                hi_hold = b;
                if (eom)
                    emit(KIND_ERROR, 8'h00, 16'h0000, 1'b0, ERR_TRUNCATED);
                else
                    ph = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                bytes_due = {hi_hold, b};
                if (bytes_due == 16'h0000)
                begin
                    emit(KIND_EMPTY, 8'h00, block_no, 1'b1, ERR_NONE);
                    close_block(eom);
                end
                else if (eom)
                    emit(KIND_ERROR, 8'h00, 16'h0000, 1'b0, ERR_TRUNCATED);
                else
                    ph = PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                emit(KIND_PAYLOAD, b, block_no, bytes_due == 16'd1, ERR_NONE);
                bytes_due = bytes_due - 16'd1;
                if (bytes_due == 16'h0000)
                    close_block(eom);
                else if (eom)
                    emit(KIND_ERROR, 8'h00, 16'h0000, 1'b0, ERR_TRUNCATED);
            end
            default:
                ; // done or skipping: trailing bytes give nothing
        endcase
        if (eom)
            ph = PH_VERSION;
        if (deframed_q.size() > prior_size)
        begin
            tail      = deframed_q.pop_back();
            tail.last = 1'b1;
            deframed_q.push_back(tail);
        end
    endfunction

    // ------------------------------------------------------------------
    // Result check: every accepted result against the oldest prediction
    // ------------------------------------------------------------------
    function automatic void check_field(input string what, input int want, input int got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        deframed_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (deframed_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, expected none, got kind %0d payload %0d",
                         $time, kind, payload);
            end
            else
            begin
                want = deframed_q.pop_front();
                check_field("kind", want.res.kind, kind);
                check_field("payload", want.res.payload, payload);
                check_field("block_index", want.res.block_index, block_index);
                check_field("block_end", want.res.block_end, block_end);
                check_field("error_code", want.res.error_code, error_code);
                check_field("last_result", want.last, last_result);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stall before each result, one long hold on request.
    // The hold is counted here so the sender keeps pushing and the
    // internal queue fills up behind it.
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = gaps_on ? $urandom_range(0, 4) : 0;
            if (hold_off)
            begin
                stall    = HOLD_CYCLES;
                hold_off = 1'b0;
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    // ------------------------------------------------------------------
    // Sender and configuration helpers (all entered on a falling edge)
    // ------------------------------------------------------------------

    // Offer one item; valid stays up across back-to-back items.
    task automatic send_byte(input logic [7:0] b, input logic eom);
        int gap;
        gap = gaps_on ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid       <= 1'b1;
        data_byte      <= b;
        end_of_message <= eom;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        model_byte(b, eom);
        @(negedge clk);
    endtask

    // Send the message in frame_q, end-of-message on its last byte.
    task automatic send_frame();
        for (int i = 0; i < frame_q.size(); i++)
            send_byte(frame_q[i], i == frame_q.size() - 1);
        frame_q.delete();
    endtask

    // Let every predicted result drain, then let the pipe settle; items that
    // give no result may still be in flight when the queue empties.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (deframed_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (addr == ADDR_VERSION)
            cfg_version = value[7:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic apb_check_version();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_VERSION;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        check_field("prdata", {24'h0, cfg_version}, prdata);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // Half are well-formed messages with random content; the rest are cut
    // short, carry a wrong version, a corrupted field, trailing bytes, or
    // are plain noise.
    task automatic build_random_frame();
        int blocks;
        int len;
        int cut;
        int flavour;
        frame_q.delete();
        flavour = $urandom_range(0, 11);
        if (flavour == 11)
        begin
            len = $urandom_range(1, 6);
            repeat (len) frame_q.push_back(8'($urandom));
            return;
        end
        blocks = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
        frame_q.push_back(cfg_version);
        frame_q.push_back(8'(blocks >> 8));
        frame_q.push_back(8'(blocks));
        for (int i = 0; i < blocks; i++)
        begin
            if ($urandom_range(0, 4) == 0)
                len = 0;
            else if ($urandom_range(0, 15) == 0)
                len = $urandom_range(17, 40);
            else
                len = $urandom_range(1, 8);
            frame_q.push_back(8'(len >> 8));
            frame_q.push_back(8'(len));
            repeat (len) frame_q.push_back(8'($urandom));
        end
        case (flavour)
            0: frame_q[0] = cfg_version ^ 8'($urandom_range(1, 255));
            1, 2:
            begin
                cut = $urandom_range(1, frame_q.size() - 1);
                while (frame_q.size() > cut)
                    void'(frame_q.pop_back());
            end
            3: repeat ($urandom_range(1, 4)) frame_q.push_back(8'($urandom));
            4:
            begin
                // corrupt a count, length or payload byte; large counts and
                // lengths end up truncated by the message end
                cut = $urandom_range(1, frame_q.size() - 1);
                frame_q[cut] = 8'($urandom);
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Header: zero count, short headers, wrong version with and without end, huge count.
    task automatic test_header_cases();
        frame_q = '{cfg_version, 8'h00, 8'h00};
        send_frame();
        frame_q = '{cfg_version};
        send_frame();
        frame_q = '{cfg_version, 8'hA5};
        send_frame();
        frame_q = '{cfg_version ^ 8'hFF};      // bad version on the last byte
        send_frame();
        frame_q = '{cfg_version ^ 8'h01, 8'h11}; // bad version, rest skipped
        send_frame();
        frame_q = '{cfg_version, 8'hFF, 8'hFF};  // huge count, cut at once
        send_frame();
    endtask

    // Blocks: empty block, single-byte block closing the message with a
    // trailing byte, and a payload that ends while blocks are still due.
    task automatic test_block_cases();
        frame_q = '{cfg_version, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h01, 8'hFF, 8'h3C};
        send_frame();
        frame_q = '{cfg_version, 8'h00, 8'h02, 8'h00, 8'h01, 8'h00};
        send_frame();
    endtask

    // Version register: read-back, both extremes, and a write to an
    // unmapped address that must leave the register alone.
    task automatic test_version_register();
        wait_idle();
        apb_check_version();
        apb_write(ADDR_VERSION, 32'h0000_0000);
        apb_check_version();
        frame_q = '{8'h00, 8'h00, 8'h01, 8'h00, 8'h01, 8'h5A};
        send_frame();
        wait_idle();
        apb_write(ADDR_UNMAPPED, 32'hFFFF_FFFF);
        apb_check_version();
        frame_q = '{8'h00, 8'h00, 8'h00};
        send_frame();
        wait_idle();
        apb_write(ADDR_VERSION, 32'h0000_00FF);
        apb_check_version();
        frame_q = '{8'h00, 8'h00, 8'h00};      // old version now rejected
        send_frame();
        frame_q = '{8'hFF, 8'h00, 8'h00};
        send_frame();
        wait_idle();
        apb_write(ADDR_VERSION, {24'h0, VERSION_DEFAULT});
    endtask

    // Long receiver stall against a back-to-back stream fills the queue so the input stalls.
    task automatic test_backpressure();
        wait_idle();
        gaps_on  = 1'b0;
        hold_off = 1'b1;
        frame_q = '{cfg_version, 8'h00, 8'h01, 8'h00, 8'd48};
        repeat (48) frame_q.push_back(8'($urandom));
        send_frame();
        gaps_on = 1'b1;
    endtask

    // Random messages over several version settings; one phase runs with
    // no idling on either side.
    task automatic test_random_traffic();
        logic [7:0] versions[5];
        int         target;
        versions = '{8'h00, 8'hFF, 8'($urandom), VERSION_DEFAULT, 8'($urandom)};
        for (int p = 0; p < 5; p++)
        begin
            wait_idle();
            apb_write(ADDR_VERSION, {24'h0, versions[p]});
            gaps_on = (p != 2);
            target  = parsed_items + PHASE_ITEMS;
            while (parsed_items < target)
            begin
                build_random_frame();
                send_frame();
            end
        end
        gaps_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_valid       = 1'b0;
        data_byte      = '0;
        end_of_message = 1'b0;
        cfg_version    = VERSION_DEFAULT;
        ph             = PH_VERSION;
        blocks_due     = '0;
        block_no       = '0;
        bytes_due      = '0;
        hi_hold        = '0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_header_cases();
        test_block_cases();
        test_version_register();
        test_backpressure();
        test_random_traffic();

        in_valid <= 1'b0;
        while (deframed_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
